// ===== rtl/qte_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle converter.
`default_nettype none

package qte_pkg;

    localparam int QW          = 16;
    localparam int AW          = 16;
    localparam int MFRAC       = 24;
    localparam int ANGLE_FRAC  = 13;
    localparam int ANG_SHIFT   = MFRAC - ANGLE_FRAC;
    localparam int ANGLE_LIMIT = 25736;

    localparam int PROD_W      = 2 * QW;
    localparam int NQ_W        = PROD_W + 1;
    localparam int NUM_W       = PROD_W + 3;
    localparam int QUO_W       = MFRAC + 1;
    localparam int DIVD_W      = NQ_W + QUO_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int MW          = MFRAC + 2;

    localparam int SQ_IN_W     = 2 * MW;
    localparam int SQ_STEPS    = SQ_IN_W / 2;
    localparam int SQ_ROOT_W   = SQ_STEPS;
    localparam int SQ_REM_W    = SQ_ROOT_W + 2;

    localparam int CIN_W        = MW + 2;
    localparam int CW           = CIN_W + 2;
    localparam int ZW           = 28;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;

    localparam int LATENCY = 4 + DIV_STEPS + 4 + SQ_STEPS + 1 + CORDIC_LAT + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_AXIS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPETITION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd4;

    localparam logic signed [MW-1:0] M_ONE  = MW'(1 << MFRAC);
    localparam logic signed [ZW-1:0] PI_FIX = 28'sd52707179;

    localparam logic signed [ZW-1:0] ARCTAN_TAB [CORDIC_STEPS] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef struct packed {
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [QW-1:0] quat_w;
    } quat_in_t;

    typedef struct packed {
        logic signed [AW-1:0] angle_first;
        logic signed [AW-1:0] angle_second;
        logic signed [AW-1:0] angle_third;
        logic                 zero_norm;
        logic                 gimbal_case;
    } euler_out_t;

endpackage

`default_nettype wire

// ===== rtl/qte_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module qte_div (
    input  logic                         clk,
    input  logic [qte_pkg::DIVD_W-1:0]   dividend,
    input  logic [qte_pkg::NQ_W-1:0]     divisor,
    output logic [qte_pkg::QUO_W-1:0]    quotient
);
    import qte_pkg::*;

    logic [NQ_W-1:0]  rem_reg [DIV_STEPS];
    logic [QUO_W-1:0] low_reg [DIV_STEPS];
    logic [NQ_W-1:0]  den_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [NQ_W-1:0]  rem_in;
        logic [NQ_W-1:0]  den_in;
        logic [NQ_W-1:0]  rem_next;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [NQ_W:0]    trial;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in = dividend[DIVD_W-1:QUO_W];
            assign low_in = dividend[QUO_W-1:0];
            assign den_in = divisor;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial    = {rem_in, low_in[QUO_W-1]};
        assign ge       = trial >= {1'b0, den_in};
        assign rem_next = ge ? NQ_W'(trial - {1'b0, den_in}) : NQ_W'(trial);

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            low_reg[k] <= low_in << 1;
            den_reg[k] <= den_in;
            quo_reg[k] <= {quo_in[QUO_W-2:0], ge};
        end
    end

    assign quotient = quo_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in units of 2^-24 rad.
`default_nettype none

module qte_cordic (
    input  logic                              clk,
    input  logic signed [qte_pkg::CIN_W-1:0]  y_in,
    input  logic signed [qte_pkg::CIN_W-1:0]  x_in,
    output logic signed [qte_pkg::ZW-1:0]     angle
);
    import qte_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;

    assign xe = CW'(x_in);
    assign ye = CW'(y_in);

    // fold the left half-plane onto the right
    always_ff @(posedge clk)
    begin
        if (x_in[CIN_W-1])
        begin
            x_reg[0] <= -xe;
            y_reg[0] <= -ye;
            z_reg[0] <= y_in[CIN_W-1] ? -PI_FIX : PI_FIX;
        end
        else
        begin
            x_reg[0] <= xe;
            y_reg[0] <= ye;
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (y_reg[i] == '0)
            begin
                x_reg[i+1] <= x_reg[i];
                y_reg[i+1] <= y_reg[i];
                z_reg[i+1] <= z_reg[i];
            end
            else if (!y_reg[i][CW-1])
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + ARCTAN_TAB[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - ARCTAN_TAB[i];
            end
        end
    end

    assign angle = z_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

// ===== rtl/quaternion_to_euler_angles.sv =====
// Top level: quaternion to Euler angles under a configurable axis convention.
// Throughput: one quaternion per cycle; busy stays low.
// Stages: 25-stage dividers, 26-stage square root, 25-stage CORDIC units.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Reset clears the valid pipeline and loads the register defaults.
`default_nettype none

module quaternion_to_euler_angles (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  qte_pkg::quat_in_t                  quat,
    output logic                               done,
    output qte_pkg::euler_out_t                euler,
    input  logic                               cfg_we,
    input  logic [qte_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qte_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import qte_pkg::*;

    typedef struct packed {
        logic signed [MW-1:0] tay;
        logic signed [MW-1:0] axy;
        logic signed [MW-1:0] axx;
        logic signed [MW-1:0] azy;
        logic signed [MW-1:0] azx;
        logic signed [MW-1:0] gxy;
        logic signed [MW-1:0] gxx;
        logic                 zero;
    } side_t;

    function automatic logic [1:0] next_axis(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            2'd2:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic signed [AW-1:0] angle_out(input logic signed [ZW-1:0] z);
        logic [ZW-1:0]           mag;
        logic [ZW-ANG_SHIFT-1:0] r;
        logic [AW-1:0]           lim;
        mag = z[ZW-1] ? ZW'(-z) : ZW'(z);
        r   = (ZW-ANG_SHIFT)'((mag + ZW'(1 << (ANG_SHIFT - 1))) >> ANG_SHIFT);
        lim = (r > (ZW-ANG_SHIFT)'(ANGLE_LIMIT)) ? AW'(ANGLE_LIMIT) : AW'(r);
        return z[ZW-1] ? -lim : lim;
    endfunction

    // configuration
    logic [1:0] first_axis_reg;
    logic       axis_parity_reg;
    logic       axis_repetition_reg;
    logic       rotating_frame_reg;
    logic [7:0] singular_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_axis_reg         <= 2'd0;
            axis_parity_reg        <= 1'b0;
            axis_repetition_reg    <= 1'b0;
            rotating_frame_reg     <= 1'b0;
            singular_threshold_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_AXIS: first_axis_reg         <= cfg_data[1:0];
                CFG_PARITY:     axis_parity_reg        <= cfg_data[0];
                CFG_REPETITION: axis_repetition_reg    <= cfg_data[0];
                CFG_FRAME:      rotating_frame_reg     <= cfg_data[0];
                CFG_THRESHOLD:  singular_threshold_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // valid chain
    logic valid_reg [LATENCY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LATENCY; k++)
                valid_reg[k] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
            for (int k = 1; k < LATENCY; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign busy = 1'b0;
    assign done = valid_reg[LATENCY-1];

    // stage 1: products
    logic signed [QW-1:0]     qx, qy, qz, qw;
    logic signed [PROD_W-1:0] xx1_reg, yy1_reg, zz1_reg, ww1_reg;
    logic signed [PROD_W-1:0] xy1_reg, xz1_reg, yz1_reg, xw1_reg, yw1_reg, zw1_reg;

    assign qx = quat.quat_x;
    assign qy = quat.quat_y;
    assign qz = quat.quat_z;
    assign qw = quat.quat_w;

    always_ff @(posedge clk)
    begin
        xx1_reg <= qx * qx;
        yy1_reg <= qy * qy;
        zz1_reg <= qz * qz;
        ww1_reg <= qw * qw;
        xy1_reg <= qx * qy;
        xz1_reg <= qx * qz;
        yz1_reg <= qy * qz;
        xw1_reg <= qx * qw;
        yw1_reg <= qy * qw;
        zw1_reg <= qz * qw;
    end

    // stage 2: norm and pair sums
    logic [NQ_W-1:0]         nq2_reg;
    logic signed [NUM_W-1:0] dyz2_reg, dxz2_reg, dxy2_reg;
    logic signed [NUM_W-1:0] off2_reg [6];

    always_ff @(posedge clk)
    begin
        nq2_reg  <= NQ_W'(NUM_W'(xx1_reg) + NUM_W'(yy1_reg) + NUM_W'(zz1_reg)
                          + NUM_W'(ww1_reg));
        dyz2_reg <= NUM_W'(yy1_reg) + NUM_W'(zz1_reg);
        dxz2_reg <= NUM_W'(xx1_reg) + NUM_W'(zz1_reg);
        dxy2_reg <= NUM_W'(xx1_reg) + NUM_W'(yy1_reg);
        off2_reg[0] <= NUM_W'(xy1_reg) - NUM_W'(zw1_reg);
        off2_reg[1] <= NUM_W'(xz1_reg) + NUM_W'(yw1_reg);
        off2_reg[2] <= NUM_W'(xy1_reg) + NUM_W'(zw1_reg);
        off2_reg[3] <= NUM_W'(yz1_reg) - NUM_W'(xw1_reg);
        off2_reg[4] <= NUM_W'(xz1_reg) - NUM_W'(yw1_reg);
        off2_reg[5] <= NUM_W'(yz1_reg) + NUM_W'(xw1_reg);
    end

    // stage 3: matrix numerators
    logic signed [NUM_W-1:0] nqs;
    logic signed [NUM_W-1:0] num3_reg [9];
    logic [NQ_W-1:0]         nq3_reg;
    logic                    zero3_reg;

    assign nqs = signed'(NUM_W'(nq2_reg));

    always_ff @(posedge clk)
    begin
        num3_reg[0] <= nqs - (dyz2_reg <<< 1);
        num3_reg[1] <= off2_reg[0] <<< 1;
        num3_reg[2] <= off2_reg[1] <<< 1;
        num3_reg[3] <= off2_reg[2] <<< 1;
        num3_reg[4] <= nqs - (dxz2_reg <<< 1);
        num3_reg[5] <= off2_reg[3] <<< 1;
        num3_reg[6] <= off2_reg[4] <<< 1;
        num3_reg[7] <= off2_reg[5] <<< 1;
        num3_reg[8] <= nqs - (dxy2_reg <<< 1);
        nq3_reg     <= nq2_reg;
        zero3_reg   <= nq2_reg <= NQ_W'(singular_threshold_reg);
    end

    // stage 4: dividends with rounding offset
    logic [DIVD_W-1:0] dvd4_reg [9];
    logic [8:0]        neg4_reg;
    logic [NQ_W-1:0]   nq4_reg;
    logic              zero4_reg;

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < 9; e++)
        begin
            dvd4_reg[e] <= DIVD_W'({(num3_reg[e][NUM_W-1] ? NQ_W'(-num3_reg[e])
                                                          : NQ_W'(num3_reg[e])),
                                    {MFRAC{1'b0}}})
                           + DIVD_W'(nq3_reg >> 1);
            neg4_reg[e] <= num3_reg[e][NUM_W-1];
        end
        nq4_reg   <= nq3_reg;
        zero4_reg <= zero3_reg;
    end

    // dividers
    logic [QUO_W-1:0] quo [9];

    for (genvar e = 0; e < 9; e++)
    begin : g_div
        qte_div u_div (
            .clk      (clk),
            .dividend (dvd4_reg[e]),
            .divisor  (nq4_reg),
            .quotient (quo[e])
        );
    end

    logic [8:0] negd_reg  [DIV_STEPS];
    logic       zerod_reg [DIV_STEPS];

    always_ff @(posedge clk)
    begin
        negd_reg[0]  <= neg4_reg;
        zerod_reg[0] <= zero4_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            negd_reg[k]  <= negd_reg[k-1];
            zerod_reg[k] <= zerod_reg[k-1];
        end
    end

    // stage 5: signed matrix, identity on zero norm
    logic signed [MW-1:0] m5_reg [3][3];
    logic                 zero5_reg;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (zerod_reg[DIV_STEPS-1])
                    m5_reg[r][c] <= (r == c) ? M_ONE : '0;
                else if (negd_reg[DIV_STEPS-1][3*r+c])
                    m5_reg[r][c] <= -MW'(quo[3*r+c]);
                else
                    m5_reg[r][c] <= MW'(quo[3*r+c]);
            end
        end
        zero5_reg <= zerod_reg[DIV_STEPS-1];
    end

    // stage 6: pick elements for the axis convention
    logic [1:0]           ia, ib, ic;
    logic signed [MW-1:0] sqa6_reg, sqb6_reg;
    side_t                side6_reg;

    assign ia = (first_axis_reg == 2'd3) ? 2'd2 : first_axis_reg;
    assign ib = next_axis(2'(ia + {1'b0, axis_parity_reg}));
    assign ic = next_axis(2'(ia + 2'd1 - {1'b0, axis_parity_reg}));

    always_ff @(posedge clk)
    begin
        if (axis_repetition_reg)
        begin
            sqa6_reg      <= m5_reg[ia][ib];
            sqb6_reg      <= m5_reg[ia][ic];
            side6_reg.tay <= m5_reg[ia][ia];
            side6_reg.axy <= m5_reg[ia][ib];
            side6_reg.axx <= m5_reg[ia][ic];
            side6_reg.azy <= m5_reg[ib][ia];
            side6_reg.azx <= -m5_reg[ic][ia];
        end
        else
        begin
            sqa6_reg      <= m5_reg[ia][ia];
            sqb6_reg      <= m5_reg[ib][ia];
            side6_reg.tay <= -m5_reg[ic][ia];
            side6_reg.axy <= m5_reg[ic][ib];
            side6_reg.axx <= m5_reg[ic][ic];
            side6_reg.azy <= m5_reg[ib][ia];
            side6_reg.azx <= m5_reg[ia][ia];
        end
        side6_reg.gxy  <= -m5_reg[ib][ic];
        side6_reg.gxx  <= m5_reg[ib][ib];
        side6_reg.zero <= zero5_reg;
    end

    // stages 7 and 8: sum of squares
    logic signed [SQ_IN_W-1:0] sqa7_reg, sqb7_reg;
    logic [SQ_IN_W-1:0]        rad8_reg;
    side_t                     side7_reg, side8_reg;

    always_ff @(posedge clk)
    begin
        sqa7_reg  <= sqa6_reg * sqa6_reg;
        sqb7_reg  <= sqb6_reg * sqb6_reg;
        side7_reg <= side6_reg;
        rad8_reg  <= SQ_IN_W'(sqa7_reg) + SQ_IN_W'(sqb7_reg);
        side8_reg <= side7_reg;
    end

    // integer square root, one result bit per stage
    logic [SQ_REM_W-1:0]  sq_rem_reg  [SQ_STEPS];
    logic [SQ_ROOT_W-1:0] sq_root_reg [SQ_STEPS];
    logic [SQ_IN_W-1:0]   sq_rad_reg  [SQ_STEPS];
    side_t                sided_reg   [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [SQ_REM_W-1:0]  rem_in;
        logic [SQ_ROOT_W-1:0] root_in;
        logic [SQ_IN_W-1:0]   rad_in;
        logic [SQ_REM_W+1:0]  sh;
        logic [SQ_REM_W+1:0]  trial;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad8_reg;
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign rad_in  = sq_rad_reg[k-1];
        end

        assign sh    = {rem_in, rad_in[SQ_IN_W-1 -: 2]};
        assign trial = (SQ_REM_W+2)'({root_in, 2'b01});
        assign ge    = sh >= trial;

        always_ff @(posedge clk)
        begin
            sq_rem_reg[k]  <= ge ? SQ_REM_W'(sh - trial) : SQ_REM_W'(sh);
            sq_root_reg[k] <= {root_in[SQ_ROOT_W-2:0], ge};
            sq_rad_reg[k]  <= rad_in << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        sided_reg[0] <= side8_reg;
        for (int k = 1; k < SQ_STEPS; k++)
            sided_reg[k] <= sided_reg[k-1];
    end

    // stage 9: gimbal test and CORDIC operands
    logic [SQ_ROOT_W-1:0]    s_root;
    logic signed [CIN_W-1:0] s_ext;
    side_t                   side_s;
    logic                    gimbal_now;
    logic signed [CIN_W-1:0] cy9_reg [3];
    logic signed [CIN_W-1:0] cx9_reg [3];
    logic                    gimbal9_reg, zero9_reg;

    assign s_root     = sq_root_reg[SQ_STEPS-1];
    assign side_s     = sided_reg[SQ_STEPS-1];
    assign s_ext      = signed'(CIN_W'(s_root));
    assign gimbal_now = s_root <= SQ_ROOT_W'(singular_threshold_reg);

    always_ff @(posedge clk)
    begin
        if (gimbal_now)
        begin
            cy9_reg[0] <= CIN_W'(side_s.gxy);
            cx9_reg[0] <= CIN_W'(side_s.gxx);
        end
        else
        begin
            cy9_reg[0] <= CIN_W'(side_s.axy);
            cx9_reg[0] <= CIN_W'(side_s.axx);
        end
        if (axis_repetition_reg)
        begin
            cy9_reg[1] <= s_ext;
            cx9_reg[1] <= CIN_W'(side_s.tay);
        end
        else
        begin
            cy9_reg[1] <= CIN_W'(side_s.tay);
            cx9_reg[1] <= s_ext;
        end
        cy9_reg[2]  <= CIN_W'(side_s.azy);
        cx9_reg[2]  <= CIN_W'(side_s.azx);
        gimbal9_reg <= gimbal_now;
        zero9_reg   <= side_s.zero;
    end

    // angle units
    logic signed [ZW-1:0] zc [3];

    for (genvar u = 0; u < 3; u++)
    begin : g_cordic
        qte_cordic u_cordic (
            .clk   (clk),
            .y_in  (cy9_reg[u]),
            .x_in  (cx9_reg[u]),
            .angle (zc[u])
        );
    end

    logic gimbald_reg [CORDIC_LAT];
    logic zerocd_reg  [CORDIC_LAT];

    always_ff @(posedge clk)
    begin
        gimbald_reg[0] <= gimbal9_reg;
        zerocd_reg[0]  <= zero9_reg;
        for (int k = 1; k < CORDIC_LAT; k++)
        begin
            gimbald_reg[k] <= gimbald_reg[k-1];
            zerocd_reg[k]  <= zerocd_reg[k-1];
        end
    end

    // final stage: sign, order and scaling
    logic signed [ZW-1:0] za, zb, zt, zf, zl;
    euler_out_t           euler_next;
    euler_out_t           euler_reg;

    always_comb
    begin
        za = zc[0];
        zb = zc[1];
        zt = gimbald_reg[CORDIC_LAT-1] ? '0 : zc[2];
        if (axis_parity_reg)
        begin
            za = -za;
            zb = -zb;
            zt = -zt;
        end
        zf = rotating_frame_reg ? zt : za;
        zl = rotating_frame_reg ? za : zt;
        euler_next.angle_first  = angle_out(zf);
        euler_next.angle_second = angle_out(zb);
        euler_next.angle_third  = angle_out(zl);
        euler_next.zero_norm    = zerocd_reg[CORDIC_LAT-1];
        euler_next.gimbal_case  = gimbald_reg[CORDIC_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        euler_reg <= euler_next;
    end

    assign euler = euler_reg;

endmodule

`default_nettype wire

// ===== rtl/qte_check.sv =====
// Port-level checks for the quaternion to Euler angle converter.
`default_nettype none

module qte_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 done,
    input  qte_pkg::euler_out_t  euler
);
    import qte_pkg::*;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transaction without result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without transaction");

    a_identity_angles: assert property (@(posedge clk) disable iff (!rst_n)
        (done && euler.zero_norm) |->
        (euler.angle_first == '0 && euler.angle_second == '0 && euler.angle_third == '0))
        else $error("zero norm with non-zero angles");

endmodule

bind quaternion_to_euler_angles qte_check u_qte_check (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for quaternion_to_euler_angles, covering fixed and random axis conventions and thresholds.
module tb_top;
    import qte_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASES = 10;
    localparam int AXIS_NEXT [4] = '{1, 2, 0, 1};
    localparam longint ANG_PI = 64'sd52707179;
    localparam longint ATAN_STEP [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct {
        quat_in_t   q;
        bit         known;
        euler_out_t res;
    } quat_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    quat_in_t              quat;
    logic                  done;
    euler_out_t            euler;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [1:0] axis_first_r;
    logic       parity_r;
    logic       repeat_r;
    logic       frame_r;
    logic [7:0] thresh_r;

    euler_out_t angles_due [$];
    quat_row_t  fixed_rows [$];
    int         errors;
    int         stall_count;
    int         zero_seen;
    int         gimbal_seen;
    int         sent;
    bit         no_gaps;

    quaternion_to_euler_angles DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .quat      (quat),
        .done      (done),
        .euler     (euler),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    function automatic longint scaled_ratio(longint num, longint den);
        longint unsigned mag;
        longint unsigned r;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        r = ((mag << MFRAC) + longint'(den) / 2) / longint'(den);
        return (num < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
            else if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
            else
                break;
        end
        return z;
    endfunction

    function automatic logic signed [AW-1:0] angle_fix(longint z);
        longint unsigned mag;
        longint r;
        mag = (z < 0) ? longint'(-z) : longint'(z);
        r = longint'((mag + 1024) >> 11);
        if (z < 0)
            r = -r;
        if (r > ANGLE_LIMIT)
            r = ANGLE_LIMIT;
        if (r < -ANGLE_LIMIT)
            r = -ANGLE_LIMIT;
        return AW'(r);
    endfunction

    function automatic euler_out_t predict_euler(quat_in_t q);
        longint x, y, z, w, nq, thr, s, ax, ay, az, t;
        longint m [3][3];
        int a, b, c, par;
        bit zero, gimbal;
        euler_out_t o;
        x = longint'(q.quat_x);
        y = longint'(q.quat_y);
        z = longint'(q.quat_z);
        w = longint'(q.quat_w);
        thr = longint'(thresh_r);
        par = int'(parity_r);
        nq = x * x + y * y + z * z + w * w;
        zero = nq <= thr;
        if (zero)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i][j] = (i == j) ? (64'sd1 << MFRAC) : 0;
        end
        else
        begin
            m[0][0] = scaled_ratio(nq - 2 * (y * y + z * z), nq);
            m[0][1] = scaled_ratio(2 * (x * y - z * w), nq);
            m[0][2] = scaled_ratio(2 * (x * z + y * w), nq);
            m[1][0] = scaled_ratio(2 * (x * y + z * w), nq);
            m[1][1] = scaled_ratio(nq - 2 * (x * x + z * z), nq);
            m[1][2] = scaled_ratio(2 * (y * z - x * w), nq);
            m[2][0] = scaled_ratio(2 * (x * z - y * w), nq);
            m[2][1] = scaled_ratio(2 * (y * z + x * w), nq);
            m[2][2] = scaled_ratio(nq - 2 * (x * x + y * y), nq);
        end
        a = (axis_first_r > 2) ? 2 : int'(axis_first_r);
        b = AXIS_NEXT[a + par];
        c = AXIS_NEXT[a - par + 1];
        if (repeat_r)
        begin
            s = int_root(m[a][b] * m[a][b] + m[a][c] * m[a][c]);
            gimbal = s <= thr;
            ay = vector_angle(s, m[a][a]);
            if (!gimbal)
            begin
                ax = vector_angle(m[a][b], m[a][c]);
                az = vector_angle(m[b][a], -m[c][a]);
            end
            else
            begin
                ax = vector_angle(-m[b][c], m[b][b]);
                az = 0;
            end
        end
        else
        begin
            s = int_root(m[a][a] * m[a][a] + m[b][a] * m[b][a]);
            gimbal = s <= thr;
            ay = vector_angle(-m[c][a], s);
            if (!gimbal)
            begin
                ax = vector_angle(m[c][b], m[c][c]);
                az = vector_angle(m[b][a], m[a][a]);
            end
            else
            begin
                ax = vector_angle(-m[b][c], m[b][b]);
                az = 0;
            end
        end
        if (par)
        begin
            ax = -ax;
            ay = -ay;
            az = -az;
        end
        if (frame_r)
        begin
            t = ax;
            ax = az;
            az = t;
        end
        o.angle_first  = angle_fix(ax);
        o.angle_second = angle_fix(ay);
        o.angle_third  = angle_fix(az);
        o.zero_norm    = zero;
        o.gimbal_case  = gimbal;
        return o;
    endfunction

    function automatic quat_in_t make_quat(int x, int y, int z, int w);
        quat_in_t q;
        q.quat_x = 16'(x);
        q.quat_y = 16'(y);
        q.quat_z = 16'(z);
        q.quat_w = 16'(w);
        return q;
    endfunction

    function automatic euler_out_t flat_result(bit zero);
        euler_out_t o;
        o = '0;
        o.zero_norm = zero;
        return o;
    endfunction

    function automatic logic [15:0] jitter(int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic quat_in_t random_quat();
        logic [15:0] c [4];
        int k;
        int p;
        logic [15:0] mag;
        case ($urandom_range(0, 5))
            0, 1:
                for (int i = 0; i < 4; i++)
                    c[i] = 16'($urandom);
            2:
                for (int i = 0; i < 4; i++)
                    c[i] = jitter(2);
            3:
            begin
                for (int i = 0; i < 4; i++)
                    c[i] = jitter(3);
                k = $urandom_range(0, 2);
                mag = 16'($urandom_range(1, 32767));
                c[k] = $urandom_range(0, 1) ? mag : -mag;
                c[3] = $urandom_range(0, 1) ? mag : -mag;
            end
            4:
            begin
                for (int i = 0; i < 4; i++)
                    c[i] = jitter(3);
                k = $urandom_range(0, 3);
                p = (k + $urandom_range(1, 3)) % 4;
                mag = 16'($urandom_range(1, 32767));
                c[k] = $urandom_range(0, 1) ? mag : -mag;
                c[p] = $urandom_range(0, 1) ? mag : -mag;
            end
            default:
                for (int i = 0; i < 4; i++)
                    c[i] = jitter(16384);
        endcase
        return make_quat(c[0], c[1], c[2], c[3]);
    endfunction

    task automatic send_quat(quat_in_t q);
        start <= 1'b1;
        quat  <= q;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (angles_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // hold the write enable; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_convention(logic [7:0] axis, logic [7:0] par, logic [7:0] rep,
                                  logic [7:0] frm, logic [7:0] thr);
        write_reg(CFG_FIRST_AXIS, axis);
        write_reg(CFG_PARITY, par);
        write_reg(CFG_REPETITION, rep);
        write_reg(CFG_FRAME, frm);
        write_reg(CFG_THRESHOLD, thr);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_first_r <= 2'd0;
            parity_r     <= 1'b0;
            repeat_r     <= 1'b0;
            frame_r      <= 1'b0;
            thresh_r     <= 8'd1;
        end
        else
        begin
            if (start && !busy)
                angles_due.push_back(predict_euler(quat));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIRST_AXIS: axis_first_r <= cfg_data[1:0];
                    CFG_PARITY:     parity_r     <= cfg_data[0];
                    CFG_REPETITION: repeat_r     <= cfg_data[0];
                    CFG_FRAME:      frame_r      <= cfg_data[0];
                    CFG_THRESHOLD:  thresh_r     <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (angles_due.size() == 0)
            begin
                $error("transaction out with nothing expected");
                errors++;
            end
            else
            begin
                euler_out_t e;
                e = angles_due.pop_front();
                if (euler.angle_first !== e.angle_first)
                begin
                    $error("angle_first expected %0d got %0d", e.angle_first, euler.angle_first);
                    errors++;
                end
                if (euler.angle_second !== e.angle_second)
                begin
                    $error("angle_second expected %0d got %0d", e.angle_second,
                           euler.angle_second);
                    errors++;
                end
                if (euler.angle_third !== e.angle_third)
                begin
                    $error("angle_third expected %0d got %0d", e.angle_third, euler.angle_third);
                    errors++;
                end
                if (euler.zero_norm !== e.zero_norm)
                begin
                    $error("zero_norm expected %0d got %0d", e.zero_norm, euler.zero_norm);
                    errors++;
                end
                if (euler.gimbal_case !== e.gimbal_case)
                begin
                    $error("gimbal_case expected %0d got %0d", e.gimbal_case, euler.gimbal_case);
                    errors++;
                end
                zero_seen   += e.zero_norm;
                gimbal_seen += e.gimbal_case;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        stall_count = 0;
        zero_seen   = 0;
        gimbal_seen = 0;
        sent        = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        quat      <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fixed_rows.push_back('{make_quat(0, 0, 0, 0), 1'b1, flat_result(1'b1)});
        fixed_rows.push_back('{make_quat(0, 0, 0, 16384), 1'b1, flat_result(1'b0)});
        fixed_rows.push_back('{make_quat(0, 0, 0, -16384), 1'b1, flat_result(1'b0)});
        fixed_rows.push_back('{make_quat(1, 0, 0, 0), 1'b1, flat_result(1'b1)});
        fixed_rows.push_back('{make_quat(0, 0, 0, -1), 1'b1, flat_result(1'b1)});
        fixed_rows.push_back('{make_quat(1, 1, 0, 0), 1'b0, '0});
        fixed_rows.push_back('{make_quat(-32768, -32768, -32768, -32768), 1'b0, '0});
        fixed_rows.push_back('{make_quat(32767, 32767, 32767, 32767), 1'b0, '0});
        fixed_rows.push_back('{make_quat(32767, -32768, 32767, -32768), 1'b0, '0});
        fixed_rows.push_back('{make_quat(16384, 0, 0, 0), 1'b0, '0});
        fixed_rows.push_back('{make_quat(0, 16384, 0, 0), 1'b0, '0});
        fixed_rows.push_back('{make_quat(0, 0, 16384, 0), 1'b0, '0});
        fixed_rows.push_back('{make_quat(0, 11585, 0, 11585), 1'b0, '0});
        fixed_rows.push_back('{make_quat(0, -11585, 0, 11585), 1'b0, '0});
        fixed_rows.push_back('{make_quat(11585, 0, 0, 11585), 1'b0, '0});
        fixed_rows.push_back('{make_quat(0, 0, -11585, 11585), 1'b0, '0});
        fixed_rows.push_back('{make_quat(8192, 8192, 8192, 8192), 1'b0, '0});
        fixed_rows.push_back('{make_quat(-1, 0, 0, -16384), 1'b0, '0});
        fixed_rows.push_back('{make_quat(-16384, 0, 0, 1), 1'b0, '0});
        fixed_rows.push_back('{make_quat(0, 16384, 0, -1), 1'b0, '0});

        foreach (fixed_rows[i])
        begin
            if (fixed_rows[i].known && predict_euler(fixed_rows[i].q) !== fixed_rows[i].res)
            begin
                $error("directed row %0d: predicted %h, table %h", i,
                       predict_euler(fixed_rows[i].q), fixed_rows[i].res);
                errors++;
            end
            send_quat(fixed_rows[i].q);
        end
        drain();

        // all directed rows again under a repeated-axis convention, including first axis 3
        set_convention(8'hFF, 8'h01, 8'h01, 8'h01, 8'd0);
        write_reg(3'd5, 8'hAA);
        write_reg(3'd7, 8'h55);
        cfg_we <= 1'b0;
        foreach (fixed_rows[i])
            send_quat(fixed_rows[i].q);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_convention(8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
                1: set_convention(8'd2, 8'd1, 8'd1, 8'd1, 8'd255);
                2: set_convention(8'd1, 8'd0, 8'd1, 8'd0, 8'd0);
                3: set_convention(8'd3, 8'd1, 8'd0, 8'd1, 8'd128);
                default: set_convention(8'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom));
            endcase
            cfg_we <= 1'b0;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                no_gaps = (ph == PHASES - 1) && (n >= RANDOM_ITEMS / PHASES / 2);
                if (!no_gaps && $urandom_range(0, 5) == 0)
                    hold_off($urandom_range(1, 11));
                send_quat(random_quat());
                sent++;
            end
            drain();
        end

        $display("Ran %0d directed and %0d random quaternions over %0d conventions;",
                 2 * fixed_rows.size(), sent, PHASES + 1);
        $display("%0d identity fallbacks and %0d degenerate-branch results were checked.",
                 zero_seen, gimbal_seen);
        if (errors == 0 && angles_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
